// File: src/adjacency_matrix_graph_table_core_assert.svh
// Assertion macros shared by the graph table modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef ADJACENCY_MATRIX_GRAPH_TABLE_CORE_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_TABLE_CORE_ASSERT_SVH

`ifndef SYNTH
`define AMGT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);
`define AMGT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AMGT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define AMGT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

// File: src/amgt_pkg.sv
// Types and codes for the graph table core.
// No dependencies; imported by every module of the block.
package amgt_pkg;

  localparam logic [2:0] FN_WRITE_VERTEX = 3'd0;
  localparam logic [2:0] FN_ADD_EDGE     = 3'd1;
  localparam logic [2:0] FN_FIRST        = 3'd2;
  localparam logic [2:0] FN_NEXT         = 3'd3;
  localparam logic [2:0] FN_CLEAR_EDGES  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_MORE   = 2'd2;

  localparam logic REG_VERTEX_COUNT  = 1'b0;
  localparam logic REG_NO_EDGE_VALUE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ENC,
    S_ROW,
    S_EWR,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [5:0]  vertex_count;
    logic [15:0] no_edge_value;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic encode;
    logic row_load;
    logic edge_write;
    logic vtx_write;
    logic clear;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       found1;
    logic       found2;
    logic       out_busy;
  } sts_t;

endpackage

// File: src/adjacency_matrix_graph_table_core.sv
// Graph table core: vertex value table plus symmetric adjacency matrix.
// Steps from accept to result: compare, encode, then row read or edge write for edge add
// and neighbour queries whose vertices are found; compare and encode when a lookup misses;
// compare only otherwise. The next request is taken in the cycle the result registers,
// which waits while the previous result is still held unread at the output.
// Reset (rst_n, synchronous) clears all edges at once and loads register defaults;
// the vertex table is not cleared. Depends on amgt_pkg, amgt_regs, amgt_ctrl, amgt_dp.
module adjacency_matrix_graph_table_core
  import amgt_pkg::*;
#(
  parameter int MAX_VERTICES = 32,
  parameter int VALUE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [4:0]  in_slot,
  input  logic [15:0] in_first_value,
  input  logic [15:0] in_second_value,
  input  logic [15:0] in_edge_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [4:0]  out_neighbour_index
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  amgt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  amgt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  amgt_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .VALUE_BITS   (VALUE_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_i               (cfg),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .in_func             (in_func),
    .in_slot             (in_slot),
    .in_first_value      (in_first_value),
    .in_second_value     (in_second_value),
    .in_edge_weight      (in_edge_weight),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_neighbour_index (out_neighbour_index)
  );

endmodule

// File: src/amgt_regs.sv
// APB configuration registers: vertex count and no-edge weight.
// Depends on amgt_pkg.
module amgt_regs
  import amgt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [5:0]  vertex_count_r;
  logic [15:0] no_edge_value_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r  <= 6'd0;
      no_edge_value_r <= 16'hFFFF;
    end else if (wr_en) begin
      case (paddr[2])
        REG_VERTEX_COUNT: begin
          vertex_count_r <= pwdata[5:0];
        end
        REG_NO_EDGE_VALUE: begin
          no_edge_value_r <= pwdata[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_VERTEX_COUNT:  prdata = {26'd0, vertex_count_r};
      REG_NO_EDGE_VALUE: prdata = {16'd0, no_edge_value_r};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.vertex_count  = vertex_count_r;
  assign cfg_o.no_edge_value = no_edge_value_r;

endmodule

// File: src/amgt_ctrl.sv
// Sequencer for the graph table: steps each request through its states.
// Depends on amgt_pkg and the assertion header.
`include "adjacency_matrix_graph_table_core_assert.svh"
module amgt_ctrl
  import amgt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.func inside {FN_ADD_EDGE, FN_FIRST, FN_NEXT}) state_nxt = S_ENC;
        else state_nxt = S_FIN;
      end
      S_ENC: begin
        if (sts_i.func == FN_ADD_EDGE) begin
          state_nxt = (sts_i.found1 && sts_i.found2) ? S_EWR : S_FIN;
        end else begin
          state_nxt = sts_i.found1 ? S_ROW : S_FIN;
        end
      end
      S_ROW: state_nxt = S_FIN;
      S_EWR: state_nxt = S_FIN;
      S_FIN: begin
        if (!sts_i.out_busy) state_nxt = in_valid ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd_o.capture = in_valid;
      end
      S_EXEC: begin
        cmd_o.compare   = 1'b1;
        cmd_o.vtx_write = (sts_i.func == FN_WRITE_VERTEX);
        cmd_o.clear     = (sts_i.func == FN_CLEAR_EDGES);
      end
      S_ENC: cmd_o.encode = 1'b1;
      S_ROW: cmd_o.row_load = 1'b1;
      S_EWR: cmd_o.edge_write = 1'b1;
      S_FIN: begin
        in_ready       = !sts_i.out_busy;
        cmd_o.out_load = !sts_i.out_busy;
        cmd_o.capture  = !sts_i.out_busy && in_valid;
      end
      default: begin
      end
    endcase
  end

  `AMGT_ASSERT_IMP(a_load_free, clk, rst_n, cmd_o.out_load, !sts_i.out_busy, "result overwritten")
  `AMGT_ASSERT_NXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_r == S_EXEC, "request not started")
  `AMGT_ASSERT_IMP(a_edge_found, clk, rst_n, cmd_o.edge_write, sts_i.found1 && sts_i.found2 && (sts_i.func == FN_ADD_EDGE), "edge write without both ends")

endmodule

// File: src/amgt_dp.sv
// Datapath: vertex table, adjacency rows, match vectors and result register.
// Depends on amgt_pkg and the assertion header.
`include "adjacency_matrix_graph_table_core_assert.svh"
module amgt_dp
  import amgt_pkg::*;
#(
  parameter int MAX_VERTICES = 32,
  parameter int VALUE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [2:0]  in_func,
  input  logic [4:0]  in_slot,
  input  logic [15:0] in_first_value,
  input  logic [15:0] in_second_value,
  input  logic [15:0] in_edge_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [4:0]  out_neighbour_index
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  function automatic logic [IDX_W-1:0] first_set(input logic [MAX_VERTICES-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  logic [2:0]              func_r;
  logic [4:0]              slot_r;
  logic [VALUE_BITS-1:0]   v1_r;
  logic [VALUE_BITS-1:0]   v2_r;
  logic [15:0]             weight_r;
  logic [VALUE_BITS-1:0]   vtx_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] m1_r, m2_r, m1_nxt, m2_nxt;
  logic [MAX_VERTICES-1:0] row_r, row_nxt;
  logic [IDX_W-1:0]        x_r, y_r, nb;
  logic [CNT_W-1:0]        n_use, start;
  logic                    out_valid_r;
  logic [1:0]              out_status_r, res_status;
  logic [4:0]              out_idx_r, res_idx;
  logic                    present;

  always_comb begin
    if (int'(cfg_i.vertex_count) > MAX_VERTICES) n_use = CNT_W'(MAX_VERTICES);
    else n_use = CNT_W'(cfg_i.vertex_count);
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      func_r   <= in_func;
      slot_r   <= in_slot;
      v1_r     <= VALUE_BITS'(in_first_value);
      v2_r     <= VALUE_BITS'(in_second_value);
      weight_r <= in_edge_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.vtx_write && (int'(slot_r) < MAX_VERTICES)) begin
      vtx_r[IDX_W'(slot_r)] <= v1_r;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      m1_nxt[i] = (CNT_W'(i) < n_use) && (vtx_r[i] == v1_r);
      m2_nxt[i] = (CNT_W'(i) < n_use) && (vtx_r[i] == v2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.compare) begin
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
    end
    if (cmd_i.encode) begin
      x_r <= first_set(m1_r);
      y_r <= first_set(m2_r);
    end
    if (cmd_i.row_load) row_r <= row_nxt;
  end

  assign start = ((func_r == FN_NEXT) && (|m2_r)) ? (CNT_W'(y_r) + CNT_W'(1)) : '0;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      row_nxt[i] = adj_r[x_r][i] && (CNT_W'(i) >= start) && (CNT_W'(i) < n_use);
    end
  end

  assign present = (weight_r != cfg_i.no_edge_value);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd_i.clear) begin
      for (int r = 0; r < MAX_VERTICES; r++) adj_r[r] <= '0;
    end else if (cmd_i.edge_write) begin
      adj_r[x_r][y_r] <= present;
      adj_r[y_r][x_r] <= present;
    end
  end

  assign nb = first_set(row_r);

  always_comb begin
    res_status = ST_OK;
    res_idx    = 5'd0;
    case (func_r)
      FN_ADD_EDGE: begin
        if (!(|m1_r && |m2_r)) res_status = ST_NOT_FOUND;
      end
      FN_FIRST, FN_NEXT: begin
        if (!(|m1_r)) res_status = ST_NOT_FOUND;
        else if (|row_r) res_idx = 5'(nb);
        else res_status = ST_NO_MORE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_status_r <= res_status;
      out_idx_r    <= res_idx;
    end
  end

  assign sts_o.func     = func_r;
  assign sts_o.found1   = |m1_r;
  assign sts_o.found2   = |m2_r;
  assign sts_o.out_busy = out_valid_r && !out_ready;

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_neighbour_index = out_idx_r;

  `AMGT_ASSERT_IMP(a_idx_zero, clk, rst_n, out_valid_r && (out_status_r != ST_OK), out_idx_r == 5'd0, "index set on failed query")
  `AMGT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r && $stable(out_status_r) && $stable(out_idx_r), "result changed while waiting")
  `AMGT_ASSERT_IMP(a_status_code, clk, rst_n, out_valid_r, (out_status_r == ST_OK) || (out_status_r == ST_NOT_FOUND) || (out_status_r == ST_NO_MORE), "bad status code")

endmodule
